// ----- rtl/rieu_pkg.sv -----
package rieu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned NREG = 32;
	localparam int unsigned RIDX = 5;

	typedef enum logic [5:0] {
		OP_ADD   = 6'd0,  OP_ADDU  = 6'd1,  OP_SUB   = 6'd2,  OP_SUBU  = 6'd3,
		OP_AND   = 6'd4,  OP_OR    = 6'd5,  OP_XOR   = 6'd6,  OP_NOR   = 6'd7,
		OP_SLT   = 6'd8,  OP_SLTU  = 6'd9,  OP_SLL   = 6'd10, OP_SRL   = 6'd11,
		OP_SRA   = 6'd12, OP_SLLV  = 6'd13, OP_SRLV  = 6'd14, OP_SRAV  = 6'd15,
		OP_MOVE  = 6'd16, OP_NOT   = 6'd17, OP_NEG   = 6'd18, OP_ABS   = 6'd19,
		OP_MULT  = 6'd20, OP_MULTU = 6'd21, OP_DIV   = 6'd22, OP_DIVU  = 6'd23,
		OP_MFHI  = 6'd24, OP_MFLO  = 6'd25, OP_MTHI  = 6'd26, OP_MTLO  = 6'd27,
		OP_ADDI  = 6'd28, OP_ADDIU = 6'd29, OP_ANDI  = 6'd30, OP_ORI   = 6'd31,
		OP_XORI  = 6'd32, OP_LUI   = 6'd33, OP_SLTI  = 6'd34, OP_SLTIU = 6'd35,
		OP_LI    = 6'd36, OP_BEQ   = 6'd37, OP_BNE   = 6'd38, OP_BLEZ  = 6'd39,
		OP_BGTZ  = 6'd40, OP_BLTZ  = 6'd41, OP_BGEZ  = 6'd42, OP_BLE   = 6'd43,
		OP_BGE   = 6'd44
	} op_t;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OVF  = 2'd1;
	localparam logic [1:0] ERR_DIV0 = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RDA  = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_ITER = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

endpackage

// ----- rtl/risc_integer_execute_unit.sv -----
// Integer execute unit: one decoded instruction per input word, against a
// 32 x 32 register file and the HI/LO pair.
// Input s_axis: tdata = req_type[5:0], dest_reg[10:6], src_a_reg[15:11],
// src_b_reg[20:16], shift_amount[25:21], immediate[57:26], zero pad to 64.
// Output m_axis: tdata = write_enable[0], write_reg[5:1], write_value[37:6],
// branch_taken[38], error_code[40:39], zero pad to 48.
// One instruction is worked at a time; s_axis_tready is low meanwhile.
// Register file is a memory with registered read: src_a is read as the
// word is taken and src_b in ST_RDA, then ST_EXEC works the op.
// mult/multu iterate a shift-add in ST_ITER, div/divu a restoring
// subtract (one bit per cycle on one shared 33-bit adder); both end
// in ST_OUT like plain ops.
// The result word sits in an output register until m_axis_tready; the next
// instruction is taken only after that, so a stalled receiver holds the unit.
// Reset: HI, LO and the register file read as zero (valid bit per entry,
// cleared by arst_n at once), no clearing pass.
module risc_integer_execute_unit
	import rieu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // req_type, dest_reg, src_a_reg, src_b_reg, shift_amount, immediate
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // write_enable, write_reg, write_value, branch_taken, error_code
);

	state_t state_q;
	logic [5:0] op_q;
	logic [RIDX-1:0] rd_q, ra_q, rb_q, sh_q;
	logic [XLEN-1:0] imm_q, a_q, b_q, hi_q, lo_q;
	logic [XLEN-1:0] mem [NREG];
	logic [NREG-1:0] vld_q;
	logic [XLEN-1:0] rdat_q;
	logic [RIDX-1:0] raddr;
	logic [4:0] cnt_q;
	// iterative unit: acc_q is the upper half / remainder, mq_q multiplier / quotient
	logic [XLEN-1:0] acc_q, mq_q, dvs_q;
	logic neg_q, negr_q;
	logic we_q, tk_q;
	logic [RIDX-1:0] wr_q;
	logic [XLEN-1:0] wv_q;
	logic [1:0] err_q;
	logic ovalid_q;

	logic [XLEN:0] addr_r;
	logic [XLEN-1:0] val, ea, eb, ma, mb, imm16;
	logic wr, tk;
	logic [1:0] err;
	logic iter_mul;
	logic [XLEN:0] alu_x, alu_y, alu_r;
	logic slt_ab, slt_ai, az;

	assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {7'd0, err_q, tk_q, wv_q, wr_q, we_q};
	assign raddr = (state_q == ST_IDLE) ? s_axis_tdata[15:11] : rb_q;

	always_ff @(posedge clk) begin
		rdat_q <= mem[raddr];
		if (state_q == ST_EXEC && wr && rd_q != '0)
			mem[rd_q] <= val;
	end

	// operand values, register 0 and unwritten entries read as zero
	assign ea = a_q;
	assign eb = (rb_q != '0 && vld_q[rb_q]) ? rdat_q : '0;
	assign imm16 = {16'd0, imm_q[15:0]};
	assign ma = ea[XLEN-1] ? (~ea + 1'b1) : ea;
	assign mb = eb[XLEN-1] ? (~eb + 1'b1) : eb;
	assign slt_ab = $signed(ea) < $signed(eb);
	assign slt_ai = $signed(ea) < $signed(imm_q);
	assign az = (ea == '0);

	always_comb begin
		val = '0;
		wr = 1'b0;
		tk = 1'b0;
		err = ERR_NONE;
		addr_r = '0;
		case (op_t'(op_q))
			OP_ADD, OP_ADDI: begin
				addr_r = {1'b0, ea + ((op_q == OP_ADD) ? eb : imm_q)};
				val = addr_r[XLEN-1:0];
				if ((ea[XLEN-1] == ((op_q == OP_ADD) ? eb[XLEN-1] : imm_q[XLEN-1]))
						&& (val[XLEN-1] != ea[XLEN-1]))
					err = ERR_OVF;
				else
					wr = 1'b1;
			end
			OP_ADDU:  begin val = ea + eb; wr = 1'b1; end
			OP_SUB: begin
				val = ea - eb;
				if ((ea[XLEN-1] != eb[XLEN-1]) && (val[XLEN-1] != ea[XLEN-1]))
					err = ERR_OVF;
				else
					wr = 1'b1;
			end
			OP_SUBU:  begin val = ea - eb; wr = 1'b1; end
			OP_AND:   begin val = ea & eb; wr = 1'b1; end
			OP_OR:    begin val = ea | eb; wr = 1'b1; end
			OP_XOR:   begin val = ea ^ eb; wr = 1'b1; end
			OP_NOR:   begin val = ~(ea | eb); wr = 1'b1; end
			OP_SLT:   begin val = {31'd0, slt_ab}; wr = 1'b1; end
			OP_SLTU:  begin val = {31'd0, ea < eb}; wr = 1'b1; end
			OP_SLL:   begin val = eb << sh_q; wr = 1'b1; end
			OP_SRL:   begin val = eb >> sh_q; wr = 1'b1; end
			OP_SRA:   begin val = $unsigned($signed(eb) >>> sh_q); wr = 1'b1; end
			OP_SLLV:  begin val = eb << ea[4:0]; wr = 1'b1; end
			OP_SRLV:  begin val = eb >> ea[4:0]; wr = 1'b1; end
			OP_SRAV:  begin val = $unsigned($signed(eb) >>> ea[4:0]); wr = 1'b1; end
			OP_MOVE:  begin val = ea; wr = 1'b1; end
			OP_NOT:   begin val = ~ea; wr = 1'b1; end
			OP_NEG:   begin val = ~ea + 1'b1; wr = 1'b1; end
			OP_ABS:   begin val = ma; wr = 1'b1; end
			OP_DIV, OP_DIVU: if (eb == '0) err = ERR_DIV0;
			OP_MFHI:  begin val = hi_q; wr = 1'b1; end
			OP_MFLO:  begin val = lo_q; wr = 1'b1; end
			OP_ADDIU: begin val = ea + imm_q; wr = 1'b1; end
			OP_ANDI:  begin val = ea & imm16; wr = 1'b1; end
			OP_ORI:   begin val = ea | imm16; wr = 1'b1; end
			OP_XORI:  begin val = ea ^ imm16; wr = 1'b1; end
			OP_LUI:   begin val = {imm_q[15:0], 16'd0}; wr = 1'b1; end
			OP_SLTI:  begin val = {31'd0, slt_ai}; wr = 1'b1; end
			OP_SLTIU: begin val = {31'd0, ea < imm16}; wr = 1'b1; end
			OP_LI:    begin val = imm_q; wr = 1'b1; end
			OP_BEQ:   tk = (ea == eb);
			OP_BNE:   tk = (ea != eb);
			OP_BLEZ:  tk = ea[XLEN-1] | az;
			OP_BGTZ:  tk = !ea[XLEN-1] && !az;
			OP_BLTZ:  tk = ea[XLEN-1];
			OP_BGEZ:  tk = !ea[XLEN-1];
			OP_BLE:   tk = !($signed(eb) < $signed(ea));
			OP_BGE:   tk = !slt_ab;
			default: ;
		endcase
	end

	// shared 33-bit adder: add for multiply, trial subtract for divide
	assign iter_mul = (op_q == OP_MULT) || (op_q == OP_MULTU);
	assign alu_x = iter_mul ? {1'b0, acc_q} : {acc_q, mq_q[XLEN-1]};
	assign alu_y = iter_mul ? {1'b0, (mq_q[0] ? dvs_q : '0)} : ~{1'b0, dvs_q};
	assign alu_r = alu_x + alu_y + {{XLEN{1'b0}}, !iter_mul};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			vld_q    <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (ovalid_q && m_axis_tready)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					op_q  <= s_axis_tdata[5:0];
					rd_q  <= s_axis_tdata[10:6];
					ra_q  <= s_axis_tdata[15:11];
					rb_q  <= s_axis_tdata[20:16];
					sh_q  <= s_axis_tdata[25:21];
					imm_q <= s_axis_tdata[57:26];
					state_q <= ST_RDA;
				end
				ST_RDA: begin
					a_q <= (ra_q != '0 && vld_q[ra_q]) ? rdat_q : '0;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					we_q  <= wr && (rd_q != '0);
					wr_q  <= (wr && rd_q != '0) ? rd_q : '0;
					wv_q  <= (wr && rd_q != '0) ? val : '0;
					tk_q  <= tk;
					err_q <= err;
					if (wr && rd_q != '0)
						vld_q[rd_q] <= 1'b1;
					cnt_q <= '0;
					acc_q <= '0;
					if (op_q == OP_MULT) begin
						mq_q  <= ma;
						dvs_q <= mb;
						neg_q <= ea[XLEN-1] ^ eb[XLEN-1];
						state_q <= ST_ITER;
					end else if (op_q == OP_MULTU) begin
						mq_q  <= ea;
						dvs_q <= eb;
						neg_q <= 1'b0;
						state_q <= ST_ITER;
					end else if ((op_q == OP_DIV || op_q == OP_DIVU) && eb != '0) begin
						mq_q  <= (op_q == OP_DIV) ? ma : ea;
						dvs_q <= (op_q == OP_DIV) ? mb : eb;
						neg_q  <= (op_q == OP_DIV) && (ea[XLEN-1] ^ eb[XLEN-1]);
						negr_q <= (op_q == OP_DIV) && ea[XLEN-1];
						state_q <= ST_ITER;
					end else begin
						if (op_q == OP_MTHI) hi_q <= ea;
						if (op_q == OP_MTLO) lo_q <= ea;
						state_q <= ST_OUT;
					end
				end
				ST_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (iter_mul) begin
						{acc_q, mq_q} <= {alu_r, mq_q[XLEN-1:1]};
						if (cnt_q == 5'd31) begin
							if (neg_q)
								{hi_q, lo_q} <= ~{alu_r, mq_q[XLEN-1:1]} + 1'b1;
							else
								{hi_q, lo_q} <= {alu_r, mq_q[XLEN-1:1]};
						end
					end else begin
						if (!alu_r[XLEN]) begin
							acc_q <= alu_r[XLEN-1:0];
							mq_q  <= {mq_q[XLEN-2:0], 1'b1};
						end else begin
							acc_q <= {acc_q[XLEN-2:0], mq_q[XLEN-1]};
							mq_q  <= {mq_q[XLEN-2:0], 1'b0};
						end
						if (cnt_q == 5'd31) begin
							if (!alu_r[XLEN]) begin
								lo_q <= neg_q ? ~{mq_q[XLEN-2:0], 1'b1} + 1'b1
									: {mq_q[XLEN-2:0], 1'b1};
								hi_q <= negr_q ? ~alu_r[XLEN-1:0] + 1'b1 : alu_r[XLEN-1:0];
							end else begin
								lo_q <= neg_q ? ~{mq_q[XLEN-2:0], 1'b0} + 1'b1
									: {mq_q[XLEN-2:0], 1'b0};
								hi_q <= negr_q ? ~{acc_q[XLEN-2:0], mq_q[XLEN-1]} + 1'b1
									: {acc_q[XLEN-2:0], mq_q[XLEN-1]};
							end
						end
					end
					if (cnt_q == 5'd31)
						state_q <= ST_OUT;
				end
				ST_OUT: if (!ovalid_q) begin
					ovalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> state_q != ST_ITER) else $error("result pending during iteration");
	a_we_reg: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && we_q |-> wr_q != '0) else $error("write to register zero reported");
	a_err_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && err_q != ERR_NONE |-> !we_q) else $error("write despite trap");
	a_iter_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ITER && cnt_q == 5'd31 |=> state_q == ST_OUT)
		else $error("iteration overrun");

endmodule
